>>> hdl/ils_pkg.sv
// Shared types and constants for the indexed list store.
// Holds the item structs, action and status codes and the sequencer states.
// No dependencies.
package ils_pkg;

	localparam int CAPACITY = 256;
	localparam int ADDR_W   = 8;
	localparam int CNT_W    = 9;
	localparam int DATA_W   = 32;

	// Action codes
	localparam logic [2:0] ACT_APPEND = 3'd0;
	localparam logic [2:0] ACT_INSERT = 3'd1;
	localparam logic [2:0] ACT_READ   = 3'd2;
	localparam logic [2:0] ACT_WRITE  = 3'd3;
	localparam logic [2:0] ACT_REMOVE = 3'd4;
	localparam logic [2:0] ACT_FIND   = 3'd5;

	// Status codes
	localparam logic [2:0] STS_OK       = 3'd0;
	localparam logic [2:0] STS_EMPTY    = 3'd1;
	localparam logic [2:0] STS_RANGE    = 3'd2;
	localparam logic [2:0] STS_FULL     = 3'd3;
	localparam logic [2:0] STS_NOTFOUND = 3'd4;

	typedef struct packed {
		logic [2:0]               action;
		logic [ADDR_W-1:0]        position;
		logic signed [DATA_W-1:0] item_value;
	} req_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] read_value;
		logic                     found;
		logic [2:0]               status;
		logic [CNT_W-1:0]         entry_count;
	} rsp_t;

	// Sequencer handshake status from the core to the top level
	typedef struct packed {
		logic idle;
		logic done;
	} core_sts_t;

	typedef enum logic [2:0] {
		CS_IDLE,
		CS_INS_MV,
		CS_INS_PUT,
		CS_RD_WAIT,
		CS_SCAN,
		CS_RM_MV,
		CS_DONE
	} core_state_t;

endpackage

>>> hdl/ils_core.sv
// Storage and sequencer of the indexed list store: entry memory, count and
// the stepping logic for shift, scan and access. Depends on ils_pkg.
module ils_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  ils_pkg::req_t     req,
	input  logic              take,
	output ils_pkg::core_sts_t sts,
	output ils_pkg::rsp_t     res
);
	import ils_pkg::*;

	logic [DATA_W-1:0] mem [CAPACITY];
	logic [DATA_W-1:0] rdata_q;
	logic              we;
	logic [ADDR_W-1:0] waddr;
	logic [ADDR_W-1:0] raddr;
	logic [DATA_W-1:0] wdata;

	core_state_t       state_q, state_d;
	logic [CNT_W-1:0]  count_q, count_d;
	logic [ADDR_W-1:0] idx_q, idx_d;
	logic [ADDR_W-1:0] pos_q, pos_d;
	logic [DATA_W-1:0] val_q, val_d;
	logic              rem_q, rem_d;
	logic [DATA_W-1:0] rv_q, rv_d;
	logic              fnd_q, fnd_d;
	logic [2:0]        st_q, st_d;

	logic [CNT_W-1:0]  idx_ext;
	logic              hit;

	assign idx_ext = {1'b0, idx_q};
	// shared compare unit: stored entry against the searched value
	assign hit = (rdata_q == val_q);

	// Entry memory: one write and one registered read a cycle
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	// State and control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CS_IDLE;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
		end
	end

	// Working registers of the current item
	always_ff @(posedge clk) begin
		idx_q <= idx_d;
		pos_q <= pos_d;
		val_q <= val_d;
		rem_q <= rem_d;
		rv_q  <= rv_d;
		fnd_q <= fnd_d;
		st_q  <= st_d;
	end

	// Next state, memory controls and result fields
	always_comb begin
		state_d = state_q;
		count_d = count_q;
		idx_d   = idx_q;
		pos_d   = pos_q;
		val_d   = val_q;
		rem_d   = rem_q;
		rv_d    = rv_q;
		fnd_d   = fnd_q;
		st_d    = st_q;
		we      = 1'b0;
		waddr   = idx_q;
		wdata   = rdata_q;
		raddr   = '0;

		case (state_q)
			CS_IDLE: begin
				if (start) begin
					pos_d   = req.position;
					val_d   = req.item_value;
					rem_d   = (req.action == ACT_REMOVE);
					rv_d    = '0;
					fnd_d   = 1'b0;
					st_d    = STS_OK;
					state_d = CS_DONE;
					case (req.action)
						ACT_APPEND: begin
							if (count_q == CNT_W'(CAPACITY)) begin
								st_d = STS_FULL;
							end else begin
								we      = 1'b1;
								waddr   = count_q[ADDR_W-1:0];
								wdata   = req.item_value;
								count_d = count_q + CNT_W'(1);
							end
						end
						ACT_INSERT: begin
							if (count_q == '0) begin
								we      = 1'b1;
								waddr   = '0;
								wdata   = req.item_value;
								count_d = CNT_W'(1);
							end else if ({1'b0, req.position} >= count_q) begin
								st_d = STS_RANGE;
							end else if (count_q == CNT_W'(CAPACITY)) begin
								st_d = STS_FULL;
							end else begin
								// open a gap: move entries up from the tail
								idx_d   = count_q[ADDR_W-1:0];
								raddr   = count_q[ADDR_W-1:0] - ADDR_W'(1);
								state_d = CS_INS_MV;
							end
						end
						ACT_READ, ACT_WRITE: begin
							if (count_q == '0) begin
								st_d = STS_EMPTY;
							end else if ({1'b0, req.position} >= count_q) begin
								st_d = STS_RANGE;
							end else if (req.action == ACT_READ) begin
								raddr   = req.position;
								state_d = CS_RD_WAIT;
							end else begin
								we    = 1'b1;
								waddr = req.position;
								wdata = req.item_value;
							end
						end
						ACT_REMOVE, ACT_FIND: begin
							if (count_q == '0) begin
								st_d = STS_EMPTY;
							end else begin
								idx_d   = '0;
								raddr   = '0;
								state_d = CS_SCAN;
							end
						end
						default: begin
						end
					endcase
				end
			end
			CS_INS_MV: begin
				// move entry idx-1 up to idx, fetch the next one down
				we    = 1'b1;
				waddr = idx_q;
				wdata = rdata_q;
				if (idx_q - ADDR_W'(1) == pos_q) begin
					state_d = CS_INS_PUT;
				end else begin
					raddr = idx_q - ADDR_W'(2);
					idx_d = idx_q - ADDR_W'(1);
				end
			end
			CS_INS_PUT: begin
				we      = 1'b1;
				waddr   = pos_q;
				wdata   = val_q;
				count_d = count_q + CNT_W'(1);
				state_d = CS_DONE;
			end
			CS_RD_WAIT: begin
				rv_d    = rdata_q;
				state_d = CS_DONE;
			end
			CS_SCAN: begin
				// compare one entry a cycle, fetch the following one
				if (hit) begin
					fnd_d = 1'b1;
					if (rem_q && (idx_ext + CNT_W'(1) < count_q)) begin
						raddr   = idx_q + ADDR_W'(1);
						state_d = CS_RM_MV;
					end else begin
						if (rem_q) begin
							count_d = count_q - CNT_W'(1);
						end
						state_d = CS_DONE;
					end
				end else if (idx_ext + CNT_W'(1) == count_q) begin
					st_d    = STS_NOTFOUND;
					state_d = CS_DONE;
				end else begin
					raddr = idx_q + ADDR_W'(1);
					idx_d = idx_q + ADDR_W'(1);
				end
			end
			CS_RM_MV: begin
				// close the gap: move entry idx+1 down to idx
				we    = 1'b1;
				waddr = idx_q;
				wdata = rdata_q;
				if (idx_ext + CNT_W'(2) < count_q) begin
					raddr = idx_q + ADDR_W'(2);
					idx_d = idx_q + ADDR_W'(1);
				end else begin
					count_d = count_q - CNT_W'(1);
					state_d = CS_DONE;
				end
			end
			CS_DONE: begin
				if (take) begin
					state_d = CS_IDLE;
				end
			end
			default: begin
				state_d = CS_IDLE;
			end
		endcase
	end

	assign sts.idle = (state_q == CS_IDLE);
	assign sts.done = (state_q == CS_DONE);

	assign res.read_value  = rv_q;
	assign res.found       = fnd_q;
	assign res.status      = st_q;
	assign res.entry_count = count_q;

	// Count stays within the store
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("entry count above capacity");

	// Count only moves when an item finishes
	a_count_done: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != $past(count_q)) |-> (state_q == CS_DONE))
		else $error("entry count changed mid-item");

	// Scan and shift-down indices stay inside the list
	a_scan_idx: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == CS_SCAN || state_q == CS_RM_MV) |-> (idx_ext < count_q))
		else $error("scan index outside list");

	// No writes while scanning, reading back or holding a result
	a_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == CS_SCAN || state_q == CS_RD_WAIT || state_q == CS_DONE) |-> !we)
		else $error("unexpected memory write");

	// Insert shift stays above the target position
	a_ins_idx: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == CS_INS_MV) |-> (idx_q > pos_q))
		else $error("insert shift passed target");

endmodule

>>> hdl/indexed_list_store_top.sv
// Top level of the indexed list store: request capture and result register.
// Instantiates ils_core; depends on ils_pkg.
//
// Usage:
// - Requests arrive on req/req_valid and are taken at an edge where
//   req_valid is high and req_stall low. Each request gives one result on
//   rsp/rsp_valid, taken when rsp_valid is high and rsp_stall low.
// - One request is worked on at a time. Append, write, rejected requests
//   and unused action codes finish straight from idle in the core; read
//   waits for the registered memory read. Insert moves one entry a cycle
//   up from the tail, then writes the new item. Find scans the entries
//   in order until a match or the end; remove then moves each entry after
//   the match down. A finished result then passes to the result register.
// - A new request is taken as soon as the core is idle, even while the
//   previous result still waits in the result register.
// - While rsp_stall is high a valid result holds; a finished item then waits
//   in the core, and req_stall stays high until it can move out.
// - Reset empties the list and clears the result valid flag. Memory
//   contents are not cleared; only positions below the count are ever read.
module indexed_list_store_top (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  ils_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output ils_pkg::rsp_t rsp
);
	import ils_pkg::*;

	core_sts_t sts;
	rsp_t      core_res;
	logic      start;
	logic      take;
	logic      rsp_valid_q;
	rsp_t      rsp_q;

	assign req_stall = !sts.idle;
	assign start     = req_valid && sts.idle;
	// move a finished item out when the result slot is free or emptying
	assign take      = sts.done && (!rsp_valid_q || !rsp_stall);

	ils_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.req    (req),
		.take   (take),
		.sts    (sts),
		.res    (core_res)
	);

	// Result valid: set on load, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (take) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// Result payload: hold while stalled
	always_ff @(posedge clk) begin
		if (take) begin
			rsp_q <= core_res;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

>>> sim/tb_top.sv
// Self-checking testbench for indexed_list_store_top: directed and random list requests.
// Predicts every result in-line and checks it field by field; depends on ils_pkg and the RTL.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import ils_pkg::*;

	localparam int LIMIT_CYCLES = 3_000_000;
	localparam int LONG_HOLD    = 300;
	localparam int DRAIN_CYCLES = 300;

	// Action codes the block must ignore
	localparam logic [2:0] ACT_UNUSED_LO = 3'd6;
	localparam logic [2:0] ACT_UNUSED_HI = 3'd7;

	typedef enum int {MIX_ANY, MIX_GROW, MIX_SHRINK} mix_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;

	// Predicted list contents and length
	logic signed [DATA_W-1:0] list_vals [CAPACITY];
	int list_len = 0;

	req_t req_queue [$];
	rsp_t awaited_rsp [$];
	int pushed_total = 0;
	int accepted_total = 0;
	int send_idle_pct = 38;
	int recv_idle_pct = 58;
	int long_holds_asked = 0;
	int long_holds_done = 0;
	int hold_left = 0;
	int mismatches = 0;
	int cycle_count = 0;

	always #5 clk = ~clk;

	indexed_list_store_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	// Apply one request to the predicted list and return its result
	function automatic rsp_t list_step(req_t r);
		rsp_t o;
		int i;
		int hit;
		o = '0;
		case (r.action)
		ACT_APPEND: begin
			if (list_len >= CAPACITY) begin
				o.status = STS_FULL;
			end else begin
				list_vals[list_len] = r.item_value;
				list_len++;
			end
		end
		ACT_INSERT: begin
			if (list_len == 0) begin
				list_vals[0] = r.item_value;
				list_len = 1;
			end else if (r.position >= list_len) begin
				o.status = STS_RANGE;
			end else if (list_len >= CAPACITY) begin
				o.status = STS_FULL;
			end else begin
				for (i = list_len; i > r.position; i--)
					list_vals[i] = list_vals[i - 1];
				list_vals[r.position] = r.item_value;
				list_len++;
			end
		end
		ACT_READ, ACT_WRITE: begin
			if (list_len == 0)
				o.status = STS_EMPTY;
			else if (r.position >= list_len)
				o.status = STS_RANGE;
			else if (r.action == ACT_READ)
				o.read_value = list_vals[r.position];
			else
				list_vals[r.position] = r.item_value;
		end
		ACT_REMOVE, ACT_FIND: begin
			// first match wins: scan down so the lowest index is kept
			hit = -1;
			for (i = list_len - 1; i >= 0; i--)
				if (list_vals[i] == r.item_value)
					hit = i;
			if (list_len == 0) begin
				o.status = STS_EMPTY;
			end else if (hit < 0) begin
				o.status = STS_NOTFOUND;
			end else begin
				o.found = 1'b1;
				if (r.action == ACT_REMOVE) begin
					for (i = hit; i < list_len - 1; i++)
						list_vals[i] = list_vals[i + 1];
					list_len--;
				end
			end
		end
		default: ;
		endcase
		o.entry_count = CNT_W'(list_len);
		return o;
	endfunction

	task automatic note_mismatch(string what);
		mismatches++;
		$display("ERROR at %0t: %0s", $realtime, what);
	endtask

	// Compare one accepted result with the oldest prediction
	task automatic check_result(rsp_t got);
		rsp_t want;
		if (awaited_rsp.size() == 0) begin
			note_mismatch("result arrived with no request outstanding");
			return;
		end
		want = awaited_rsp.pop_front();
		if (got.read_value !== want.read_value)
			note_mismatch($sformatf("read_value %h, expected %h",
				got.read_value, want.read_value));
		if (got.found !== want.found)
			note_mismatch($sformatf("found %b, expected %b", got.found, want.found));
		if (got.status !== want.status)
			note_mismatch($sformatf("status %0d, expected %0d", got.status, want.status));
		if (got.entry_count !== want.entry_count)
			note_mismatch($sformatf("entry_count %0d, expected %0d",
				got.entry_count, want.entry_count));
	endtask

	// Offer queued items; hold a stalled item unchanged
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
			req <= '0;
		end else begin
			if (req_valid && !req_stall) begin
				awaited_rsp.push_back(list_step(req));
				accepted_total++;
			end
			if (!(req_valid && req_stall)) begin
				if (req_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					req <= req_queue.pop_front();
					req_valid <= 1'b1;
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	// Take results, stalling at random or for one long stretch on request
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_stall <= 1'b0;
		end else begin
			if (rsp_valid && !rsp_stall)
				check_result(rsp);
			if (long_holds_done < long_holds_asked) begin
				long_holds_done++;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_stall <= 1'b1;
			end else begin
				rsp_stall <= ($urandom_range(99) < recv_idle_pct);
			end
		end
	end

	// Abandon a run that hangs
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("Timeout after %0d cycles", LIMIT_CYCLES);
			$display("Mismatches found");
			$finish;
		end
	end

	task automatic push_req(logic [2:0] act, logic [ADDR_W-1:0] pos,
			logic signed [DATA_W-1:0] val);
		req_t r;
		r.action = act;
		r.position = pos;
		r.item_value = val;
		req_queue.push_back(r);
		pushed_total++;
	endtask

	task automatic wait_all_accepted();
		while (accepted_total != pushed_total)
			@(posedge clk);
	endtask

	// A stored value at the given percentage, else mostly a small pool, so that finds and removes hit
	function automatic logic signed [DATA_W-1:0] pick_value(int list_pct);
		int r;
		r = $urandom_range(99);
		if (r < list_pct && list_len > 0)
			return list_vals[$urandom_range(list_len - 1)];
		r = $urandom_range(99);
		if (r < 45)
			return DATA_W'($urandom_range(15)) - DATA_W'(8);
		if (r < 60) begin
			case ($urandom_range(3))
			0: return 32'sh8000_0000;
			1: return 32'sh7FFF_FFFF;
			2: return 32'sd0;
			default: return -32'sd1;
			endcase
		end
		return $urandom;
	endfunction

	// Mostly in range, often exactly at the count, sometimes anywhere
	function automatic logic [ADDR_W-1:0] pick_position();
		int r;
		r = $urandom_range(99);
		if (list_len > 0 && r < 75)
			return ADDR_W'($urandom_range(list_len - 1));
		if (r < 87 && list_len < CAPACITY)
			return ADDR_W'(list_len);
		return ADDR_W'($urandom_range(CAPACITY - 1));
	endfunction

	task automatic push_chunk(mix_t mix, int n, output int useful);
		int k;
		int r;
		logic [2:0] act;
		useful = 0;
		for (k = 0; k < n; k++) begin
			r = $urandom_range(99);
			case (mix)
			MIX_GROW:
				act = (r < 50) ? ACT_APPEND : (r < 85) ? ACT_INSERT :
					(r < 93) ? ACT_READ : ACT_FIND;
			MIX_SHRINK:
				act = (r < 65) ? ACT_REMOVE : (r < 75) ? ACT_FIND :
					(r < 85) ? ACT_READ : (r < 93) ? ACT_WRITE : ACT_INSERT;
			default:
				act = (r < 17) ? ACT_APPEND : (r < 34) ? ACT_INSERT :
					(r < 50) ? ACT_READ : (r < 63) ? ACT_WRITE :
					(r < 78) ? ACT_REMOVE : (r < 97) ? ACT_FIND :
					($urandom_range(1) ? ACT_UNUSED_HI : ACT_UNUSED_LO);
			endcase
			push_req(act, pick_position(), pick_value((act == ACT_REMOVE) ? 85 : 40));
			if (act <= ACT_FIND)
				useful++;
		end
	endtask

	task automatic send_directed();
		// empty list: every access is refused
		push_req(ACT_READ, 8'd0, 32'sd0);
		push_req(ACT_WRITE, 8'd0, 32'sd9);
		push_req(ACT_REMOVE, 8'd0, 32'sd5);
		push_req(ACT_FIND, 8'd0, 32'sd5);
		// insert into an empty list ignores the position
		push_req(ACT_INSERT, 8'd255, 32'sh7FFF_FFFF);
		push_req(ACT_APPEND, 8'd0, 32'sh8000_0000);
		push_req(ACT_APPEND, 8'd0, 32'sd0);
		push_req(ACT_APPEND, 8'd170, -32'sd1);
		push_req(ACT_APPEND, 8'd85, 32'sh8000_0000);
		// insert at the front, in the middle, at the count and before the last
		push_req(ACT_INSERT, 8'd0, 32'sd11);
		push_req(ACT_INSERT, 8'd3, 32'sd22);
		push_req(ACT_INSERT, 8'd7, 32'sd44);
		push_req(ACT_INSERT, 8'd6, 32'sd33);
		// read both ends and past the count
		push_req(ACT_READ, 8'd0, 32'sd0);
		push_req(ACT_READ, 8'd7, 32'sd0);
		push_req(ACT_READ, 8'd8, 32'sd0);
		push_req(ACT_READ, 8'd255, -32'sd1);
		push_req(ACT_WRITE, 8'd4, 32'sh5555_5555);
		push_req(ACT_WRITE, 8'd8, 32'sd1);
		// find and remove with and without a match; duplicates go one at a time
		push_req(ACT_FIND, 8'd0, 32'sh8000_0000);
		push_req(ACT_FIND, 8'd0, 32'sd12345);
		push_req(ACT_REMOVE, 8'd0, 32'sh8000_0000);
		push_req(ACT_REMOVE, 8'd0, 32'sd12345);
		push_req(ACT_REMOVE, 8'd0, 32'sh8000_0000);
		// unused codes leave everything alone
		push_req(ACT_UNUSED_LO, 8'd255, -32'sd1);
		push_req(ACT_UNUSED_HI, 8'd0, 32'sh8000_0000);
		push_req(ACT_READ, 8'd4, 32'sd0);
		wait_all_accepted();
	endtask

	// Grow the list to the top and exercise the full store
	task automatic fill_store();
		int n;
		while (list_len < CAPACITY - 1) begin
			n = CAPACITY - 1 - list_len;
			if (n > 32)
				n = 32;
			repeat (n)
				push_req(ACT_APPEND, ADDR_W'($urandom), $urandom);
			wait_all_accepted();
		end
		// shift every entry once on the way to full
		push_req(ACT_INSERT, 8'd0, pick_value(50));
		push_req(ACT_APPEND, 8'd0, pick_value(0));
		push_req(ACT_INSERT, 8'd0, pick_value(0));
		push_req(ACT_INSERT, 8'd255, pick_value(0));
		push_req(ACT_READ, 8'd255, 32'sd0);
		push_req(ACT_WRITE, 8'd255, $urandom);
		push_req(ACT_READ, 8'd255, 32'sd0);
		push_req(ACT_FIND, 8'd0, pick_value(90));
		push_req(ACT_FIND, 8'd0, 32'sd12345);
		push_req(ACT_REMOVE, 8'd0, pick_value(90));
		wait_all_accepted();
	endtask

	task automatic run_random(int n_items, bit with_hold);
		int done_items;
		int got;
		int r;
		bit hold_pending;
		mix_t mix;
		done_items = 0;
		hold_pending = with_hold;
		while (done_items < n_items) begin
			if (hold_pending && done_items >= n_items / 2) begin
				long_holds_asked++;
				hold_pending = 1'b0;
			end
			// steer the length: shrink long lists, mostly grow short ones
			r = $urandom_range(99);
			if (list_len > 48)
				mix = (r < 85) ? MIX_SHRINK : MIX_ANY;
			else if (list_len < 6)
				mix = (r < 50) ? MIX_GROW : (r < 70) ? MIX_SHRINK : MIX_ANY;
			else
				mix = (r < 25) ? MIX_GROW : (r < 55) ? MIX_SHRINK : MIX_ANY;
			push_chunk(mix, 8 + $urandom_range(8), got);
			done_items += got;
			wait_all_accepted();
		end
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_directed();
		fill_store();
		run_random(470, 1'b1);
		send_idle_pct = 58;
		recv_idle_pct = 38;
		run_random(530, 1'b0);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		run_random(530, 1'b1);
		wait_all_accepted();
		while (awaited_rsp.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
